/* rtl/md5bsh_pkg.sv */
`timescale 1ns / 1ps
// Package for the MD5 byte stream hasher: word types, queue entry type,
// controller states and the MD5 step tables. No dependencies.
package md5bsh_pkg;

  // Default depth of the item queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // MD5 initial chaining values
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;

  // Padding marker byte
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       final_item;
  } md5_in_t;

  // Output word
  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } md5_out_t;

  // Classified item as held in the queue
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       is_final;
  } q_entry_t;

  // Back end controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_PREP,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } st_e;

  localparam logic [31:0] STEP_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Additive constant of a step
  function automatic logic [31:0] step_k(input logic [5:0] i);
    return STEP_K[i];
  endfunction

  // Rotate amount of a step, by round and position within the group of four
  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] s;
    s = 5'd7;
    unique case ({i[5:4], i[1:0]})
      4'b0000: s = 5'd7;
      4'b0001: s = 5'd12;
      4'b0010: s = 5'd17;
      4'b0011: s = 5'd22;
      4'b0100: s = 5'd5;
      4'b0101: s = 5'd9;
      4'b0110: s = 5'd14;
      4'b0111: s = 5'd20;
      4'b1000: s = 5'd4;
      4'b1001: s = 5'd11;
      4'b1010: s = 5'd16;
      4'b1011: s = 5'd23;
      4'b1100: s = 5'd6;
      4'b1101: s = 5'd10;
      4'b1110: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word picked by a step
  function automatic logic [3:0] msg_idx(input logic [5:0] i);
    logic [3:0] j;
    logic [3:0] g;
    j = i[3:0];
    g = j;
    unique case (i[5:4])
      2'd0: g = j;
      2'd1: g = j * 4'd5 + 4'd1;
      2'd2: g = j * 4'd3 + 4'd5;
      default: g = j * 4'd7;
    endcase
    return g;
  endfunction

  // Rotate left by 0..31
  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] w;
    w = {x, x} << s;
    return w[63:32];
  endfunction

endpackage

/* rtl/md5bsh_front.sv */
`timescale 1ns / 1ps
// Front end: accepts input words, drops empty items, queues the rest.
// Depends on md5bsh_pkg.
module md5bsh_front import md5bsh_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  md5_in_t  in_data_i,
  output logic     q_valid_o,
  output q_entry_t q_head_o,
  input  logic     q_pop_i
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  q_entry_t         mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push;
  logic             pop;
  q_entry_t         entry;

  // Classify: only items carrying a byte or the end mark go to the back
  assign entry.data     = in_data_i.data_byte;
  assign entry.has_byte = in_data_i.byte_valid;
  assign entry.is_final = in_data_i.final_item;

  assign in_stall_o = (cnt_q == CNT_FULL);
  assign push = in_valid_i && !in_stall_o && (in_data_i.byte_valid || in_data_i.final_item);
  assign pop  = q_pop_i && (cnt_q != '0);

  assign q_valid_o = (cnt_q != '0);
  assign q_head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

endmodule

/* rtl/md5bsh_core.sv */
`timescale 1ns / 1ps
// Back end: block assembly, padding, iterative MD5 compression (one step
// per cycle) and digest output register. Depends on md5bsh_pkg.
module md5bsh_core import md5bsh_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  q_entry_t q_head_i,
  output logic     q_pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output md5_out_t out_data_o
);

  st_e         st_q, st_d;
  st_e         ret_q, ret_d;
  logic [60:0] cnt_q, cnt_d;
  logic [31:0] blk_q [16];
  logic [31:0] blk_d [16];
  logic [31:0] chain_q [4];
  logic [31:0] chain_d [4];
  logic [31:0] wa_q, wa_d, wb_q, wb_d, wc_q, wc_d, wd_q, wd_d;
  logic [31:0] km_q, km_d;
  logic [5:0]  step_q, step_d;
  logic [1:0]  k_q, k_d;
  logic        out_valid_q, out_valid_d;
  md5_out_t    out_q, out_d;

  logic [5:0]  pos;
  logic [3:0]  wsel;
  logic [4:0]  lsb;
  logic [63:0] bits;
  logic [31:0] f;
  logic [31:0] t;
  logic [5:0]  nxt;

  assign pos  = cnt_q[5:0];
  assign wsel = pos[5:2];
  assign lsb  = {pos[1:0], 3'b000};
  assign bits = {cnt_q, 3'b000};
  assign nxt  = step_q + 6'd1;

  // Round function
  always_comb begin
    unique case (step_q[5:4])
      2'd0: f = (wb_q & wc_q) | (~wb_q & wd_q);
      2'd1: f = (wb_q & wd_q) | (wc_q & ~wd_q);
      2'd2: f = wb_q ^ wc_q ^ wd_q;
      default: f = wc_q ^ (wb_q | ~wd_q);
    endcase
  end

  assign t = f + wa_q + km_q;

  // Controller
  always_comb begin
    st_d        = st_q;
    ret_d       = ret_q;
    cnt_d       = cnt_q;
    blk_d       = blk_q;
    chain_d     = chain_q;
    wa_d        = wa_q;
    wb_d        = wb_q;
    wc_d        = wc_q;
    wd_d        = wd_q;
    km_d        = km_q;
    step_d      = step_q;
    k_d         = k_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    q_pop_o     = 1'b0;

    // output word taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_head_i.has_byte) begin
            blk_d[wsel][lsb +: 8] = q_head_i.data;
            cnt_d = cnt_q + 61'd1;
            if (pos == 6'd63) begin
              st_d  = ST_PREP;
              ret_d = q_head_i.is_final ? ST_PAD : ST_IDLE;
            end else if (q_head_i.is_final) begin
              st_d = ST_PAD;
            end
          end else if (q_head_i.is_final) begin
            st_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        blk_d[wsel][lsb +: 8] = PAD_BYTE;
        if (pos > 6'd55) begin
          // no room for the length: one extra block
          st_d  = ST_PREP;
          ret_d = ST_LEN;
        end else begin
          st_d = ST_LEN;
        end
      end
      ST_LEN: begin
        blk_d[14] = bits[31:0];
        blk_d[15] = bits[63:32];
        st_d      = ST_PREP;
        ret_d     = ST_EMIT;
      end
      ST_PREP: begin
        wa_d   = chain_q[0];
        wb_d   = chain_q[1];
        wc_d   = chain_q[2];
        wd_d   = chain_q[3];
        km_d   = step_k(6'd0) + blk_q[0];
        step_d = 6'd0;
        st_d   = ST_ROUND;
      end
      ST_ROUND: begin
        wa_d   = wd_q;
        wd_d   = wc_q;
        wc_d   = wb_q;
        wb_d   = wb_q + rotl32(t, rot_amt(step_q));
        // constant plus message word for the following step
        km_d   = step_k(nxt) + blk_q[msg_idx(nxt)];
        step_d = nxt;
        if (step_q == 6'd63) begin
          st_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        chain_d[0] = chain_q[0] + wa_q;
        chain_d[1] = chain_q[1] + wb_q;
        chain_d[2] = chain_q[2] + wc_q;
        chain_d[3] = chain_q[3] + wd_q;
        for (int n = 0; n < 16; n++) begin
          blk_d[n] = '0;
        end
        k_d  = 2'd0;
        st_d = ret_q;
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          out_d.digest_word = chain_q[k_q];
          out_d.word_index  = k_q;
          out_d.last_word   = (k_q == 2'd3);
          k_d               = k_q + 2'd1;
          if (k_q == 2'd3) begin
            // ready for the next message
            chain_d[0] = IV0;
            chain_d[1] = IV1;
            chain_d[2] = IV2;
            chain_d[3] = IV3;
            cnt_d      = '0;
            st_d       = ST_IDLE;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ret_q       <= ST_IDLE;
      cnt_q       <= '0;
      step_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      chain_q[0]  <= IV0;
      chain_q[1]  <= IV1;
      chain_q[2]  <= IV2;
      chain_q[3]  <= IV3;
      for (int n = 0; n < 16; n++) begin
        blk_q[n] <= '0;
      end
    end else begin
      st_q        <= st_d;
      ret_q       <= ret_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      chain_q     <= chain_d;
      blk_q       <= blk_d;
    end
  end

  // Working registers and output payload
  always_ff @(posedge clk_i) begin
    wa_q  <= wa_d;
    wb_q  <= wb_d;
    wc_q  <= wc_d;
    wd_q  <= wd_d;
    km_q  <= km_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/md5_byte_stream_hasher_unit.sv */
`timescale 1ns / 1ps
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall   | md5_in_t  (data_byte, byte_valid, final_item)
// out     | output    | out_valid / out_stall | md5_out_t (digest_word, word_index, last_word)
//
// Bytes leave the queue one at a time while the back end is idle; every 64th byte
// adds a compression (load, 64 steps of the shared round unit, fold), during which
// the queue is not read. The end mark costs one or two compressions and 4 words out.
// Reset sets the chaining words to the MD5 initial values; no clearing pass.
// A queue of QUEUE_DEPTH items lets input continue while the back end works
// or the output stalls; the output register holds one digest word.
// Top level of the MD5 byte stream hasher. Depends on md5bsh_pkg,
// md5bsh_front and md5bsh_core.
module md5_byte_stream_hasher_unit import md5bsh_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  md5_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output md5_out_t out_data_o
);

  logic     q_valid;
  q_entry_t q_head;
  logic     q_pop;

  md5bsh_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_head_o   (q_head),
    .q_pop_i    (q_pop)
  );

  md5bsh_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/md5bsh_chk.sv */
`timescale 1ns / 1ps
// Port level checker for the MD5 byte stream hasher, bound to the top level.
// Depends on md5bsh_pkg.
module md5bsh_chk import md5bsh_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input md5_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input md5_out_t out_data_o
);

  // stalled input word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input word changed while stalled");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // last flag marks index three only
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_word == (out_data_o.word_index == 2'd3)))
    else $error("last_word does not match word_index");

  // digest words follow each other without a gap, index counting up
  a_idx_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_word |=>
      out_valid_o && (out_data_o.word_index == $past(out_data_o.word_index) + 2'd1))
    else $error("digest word sequence broken");

  // nothing follows the last word straight away
  a_gap_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.last_word |=> !out_valid_o)
    else $error("word presented right after the last digest word");

endmodule

bind md5_byte_stream_hasher_unit md5bsh_chk u_chk (.*);

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for md5_byte_stream_hasher_unit: streams messages byte by byte,
// predicts each four-word digest and compares every word leaving the block.
// Depends on md5bsh_pkg (word types) and the RTL of the hasher.
import md5bsh_pkg::*;

// Digest predictor and store of expected digest words
class md5_digest_board;
  md5_out_t    digest_q[$];
  logic [31:0] chain[4];
  logic [31:0] blk[16];
  logic [60:0] nbytes;
  logic [31:0] k_tab[64];
  int          rot_tab[16];
  int          errors;

  function new();
    k_tab = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    rot_tab = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    errors  = 0;
    load_iv();
    foreach (blk[j]) blk[j] = '0;
  endfunction

  function void load_iv();
    chain[0] = 32'h67452301;
    chain[1] = 32'hefcdab89;
    chain[2] = 32'h98badcfe;
    chain[3] = 32'h10325476;
    nbytes   = '0;
  endfunction

  function logic [31:0] rotl(logic [31:0] x, int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  // 64 steps over the current block, fold into chain, clear block
  function void compress();
    logic [31:0] a, b, c, d, f, t;
    int g;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & c) | (~b & d);
        g = i;
      end else if (i < 32) begin
        f = (b & d) | (c & ~d);
        g = (5 * i + 1) & 15;
      end else if (i < 48) begin
        f = b ^ c ^ d;
        g = (3 * i + 5) & 15;
      end else begin
        f = c ^ (b | ~d);
        g = (7 * i) & 15;
      end
      t = f + a + k_tab[i] + blk[g];
      a = d;
      d = c;
      c = b;
      b = b + rotl(t, rot_tab[(i >> 4) * 4 + (i & 3)]);
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    foreach (blk[j]) blk[j] = '0;
  endfunction

  function void put_byte(logic [5:0] pos, logic [7:0] v);
    blk[pos[5:2]] |= 32'(v) << (8 * pos[1:0]);
  endfunction

  // An input word accepted by the block
  function void note_word(md5_in_t w);
    logic [5:0]  pos;
    logic [63:0] bits;
    md5_out_t    o;
    if (w.byte_valid) begin
      put_byte(nbytes[5:0], w.data_byte);
      nbytes = nbytes + 1'b1;
      if (nbytes[5:0] == 6'd0) compress();
    end
    if (!w.final_item) return;
    // padding: marker, optional extra block, then bit length
    pos = nbytes[5:0];
    put_byte(pos, 8'h80);
    if (pos > 6'd55) compress();
    bits = {nbytes, 3'b000};
    blk[14] = bits[31:0];
    blk[15] = bits[63:32];
    compress();
    for (int k = 0; k < 4; k++) begin
      o.digest_word = chain[k];
      o.word_index  = 2'(k);
      o.last_word   = (k == 3);
      digest_q.push_back(o);
    end
    load_iv();
  endfunction

  // An output word accepted from the block
  function void check_word(md5_out_t got);
    md5_out_t exp_w;
    if (digest_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected digest word: word %h index %0d last %0b",
                 got.digest_word, got.word_index, got.last_word);
      return;
    end
    exp_w = digest_q.pop_front();
    if (got !== exp_w) begin
      errors++;
      if (errors <= 10)
        $display("digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                 exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                 got.digest_word, got.word_index, got.last_word);
    end
  endfunction

  function int pending();
    return digest_q.size();
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  md5_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  md5_out_t out_data;

  md5_digest_board board = new();
  bit  in_take;
  int  cycle_cnt = 0;
  int  hold_ask = 0;
  int  hold_seen = 0;
  int  burst_left = 0;
  int  rand_items = 0;
  int  rand_msgs = 0;

  md5_byte_stream_hasher_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Mid-cycle sampling: values here are those seen by the next rising edge
  always @(negedge clk) begin
    in_take = rst_n && in_valid && !in_stall;
    if (in_take) board.note_word(in_data);
    if (rst_n && out_valid === 1'b1 && !out_stall) board.check_word(out_data);
  end

  // Offer one word, pacing in bursts; returns once the block takes it
  task automatic send_word(input md5_in_t w);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(40, 80);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(0, 7);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_take);
  endtask

  task automatic send_fields(input logic [7:0] b, input logic has_b, input logic fin);
    md5_in_t w;
    w.data_byte  = b;
    w.byte_valid = has_b;
    w.final_item = fin;
    send_word(w);
  endtask

  // One message of random bytes with occasional ignored words mixed in
  task automatic send_message(input int len);
    bit fin_on_byte;
    fin_on_byte = (len > 0) && $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_fields(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        rand_items++;
      end
      send_fields(8'($urandom_range(0, 255)), 1'b1, fin_on_byte && (i == len - 1));
      rand_items++;
    end
    if (!fin_on_byte) begin
      send_fields(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      rand_items++;
    end
    rand_msgs++;
  endtask

  // Receiver: stall windows of varying density, plus one long hold-off
  initial begin
    int win;
    int pct;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      win = $urandom_range(10, 60);
      case ($urandom_range(0, 4))
        0, 1: pct = 0;
        2: pct = 30;
        3: pct = 60;
        default: pct = 95;
      endcase
      repeat (win) begin
        @(posedge clk);
        if (hold_ask != hold_seen) begin
          hold_seen = hold_ask;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  // Sender and run control
  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ignored word, empty message, "abc" ending on its last byte
    send_fields(8'hff, 1'b0, 1'b0);
    send_fields(8'h00, 1'b0, 1'b1);
    send_fields(8'h61, 1'b1, 1'b0);
    send_fields(8'h62, 1'b1, 1'b0);
    send_fields(8'h63, 1'b1, 1'b1);
    // extreme bytes, end mark without a byte
    send_fields(8'h00, 1'b1, 1'b0);
    send_fields(8'hff, 1'b1, 1'b0);
    send_fields(8'hff, 1'b0, 1'b1);
    // single-byte message carrying the end mark, then an ignored word and an empty message
    send_fields(8'hff, 1'b1, 1'b1);
    send_fields(8'ha5, 1'b0, 1'b0);
    send_fields(8'h5a, 1'b0, 1'b1);

    // random: two-block padding, then a full block; long hold-off after the first
    send_message(56);
    hold_ask <= hold_ask + 1;
    send_message(64);
    while (rand_items < 135 || rand_msgs < 4) send_message($urandom_range(0, 12));
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
